/* rtl/assert_macros.svh */
// assertion macros used by the decoder top level
// plain text macros, no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/fupd_pkg.sv */
// types, constants and helper functions of the file uri percent decoder
// no dependencies
`default_nettype none

package fupd_pkg;

  localparam int SCHEME_LEN  = 7;
  localparam int HOST_LEN    = 9;
  localparam int MAX_RES     = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_PCT   = 8'h25;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_FILE = 2'd1;
  localparam logic [1:0] ST_NUL      = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef enum logic [2:0] {
    PH_SCHEME = 3'd0,
    PH_AFTER  = 3'd1,
    PH_AUTH   = 3'd2,
    PH_SLASH  = 3'd3,
    PH_PATH   = 3'd4,
    PH_REJECT = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_PCT  = 2'd1,
    ESC_HEX  = 2'd2
  } esc_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_data;
    logic       out_last;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic [1:0]            count;
    result_t [MAX_RES-1:0] items;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [7:0] scheme_char(input logic [3:0] idx);
    case (idx)
      4'd0:    return 8'h66;
      4'd1:    return 8'h69;
      4'd2:    return 8'h6c;
      4'd3:    return 8'h65;
      4'd4:    return 8'h3a;
      4'd5:    return 8'h2f;
      4'd6:    return 8'h2f;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] host_char(input logic [3:0] idx);
    case (idx)
      4'd0:    return 8'h6c;
      4'd1:    return 8'h6f;
      4'd2:    return 8'h63;
      4'd3:    return 8'h61;
      4'd4:    return 8'h6c;
      4'd5:    return 8'h68;
      4'd6:    return 8'h6f;
      4'd7:    return 8'h73;
      4'd8:    return 8'h74;
      default: return 8'h00;
    endcase
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic result_t data_res(input logic [7:0] b);
    result_t r;
    r.out_byte = b;
    r.has_data = 1'b1;
    r.out_last = 1'b0;
    r.status   = ST_OK;
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/fupd_in_if.sv */
// input channel of the decoder: one uri byte and its last mark per request
// no dependencies
`default_nettype none

interface fupd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

/* rtl/fupd_out_if.sv */
// output channel of the decoder: one decoded path byte or verdict per request
// no dependencies
`default_nettype none

interface fupd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_data;
  logic       out_last;
  logic [1:0] status;

  modport source (output valid, output out_byte, output has_data, output out_last,
                  output status, input ready);
  modport sink (input valid, input out_byte, input has_data, input out_last,
                input status, output ready);
endinterface

`default_nettype wire

/* rtl/file_uri_percent_decoder_unit.sv */
// top level of the file uri percent decoder
// depends on fupd_pkg, fupd_in_if, fupd_out_if, fupd_front, fupd_queue, fupd_back
// and assert_macros.svh
//
// usage:
//   uri   - one byte of uri text per request, in_last on the final byte
//   path  - decoded path bytes; the request with out_last carries the status
//           (0 ok, 1 not a local file uri, 2 decoded nul, 3 empty path); on a
//           nonzero status the receiver drops the bytes already taken
// throughput: one input byte per cycle while output keeps up; a byte yields
//   0 to 3 output requests, shown one per cycle by the back end while path is ready
// the results of a byte are registered in the queue and shown from its head
// a four-group queue sits between the front parser and the back end, so input
//   is taken while output is stalled until the queue fills
// reset: parser returns to scheme matching and the queue is emptied
`default_nettype none

module file_uri_percent_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  fupd_in_if.sink    uri,
  fupd_out_if.source path
);
  import fupd_pkg::*;

  `include "assert_macros.svh"

  entry_t push_entry;
  entry_t head;
  qstat_t qstat;
  logic   push;
  logic   pop;

  fupd_front u_front (
    .clk   (clk),
    .rst   (rst),
    .uri   (uri),
    .qstat (qstat),
    .push  (push),
    .entry (push_entry)
  );

  fupd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  fupd_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .path  (path)
  );

  `ASSERT_IMPL(a_full_stalls, clk, rst, qstat.full, !uri.ready)
  `ASSERT_IMPL(a_status_on_last, clk, rst, path.valid && !path.out_last, path.status == ST_OK)
  `ASSERT_IMPL(a_nodata_is_last, clk, rst, path.valid && !path.has_data, path.out_last)
  `ASSERT_NEXT(a_push_fills, clk, rst, push && qstat.empty && !pop, !qstat.empty)

endmodule

`default_nettype wire

/* rtl/fupd_front.sv */
// front end: prefix matcher and escape decoder, packs the results of one byte
// depends on fupd_pkg and fupd_in_if
`default_nettype none

module fupd_front (
  input  logic            clk,
  input  logic            rst,
  fupd_in_if.sink         uri,
  input  fupd_pkg::qstat_t qstat,
  output logic            push,
  output fupd_pkg::entry_t entry
);
  import fupd_pkg::*;

  phase_t     phase, phase_next, ph_step;
  logic [3:0] match_index, match_index_next, mi_step;
  esc_t       escape_pending, escape_pending_next, esc_step;
  logic [3:0] high_nibble, high_nibble_next, hn_step;
  logic [7:0] high_char, high_char_next, hc_step;
  logic [1:0] error_code, error_code_next, err_step;

  logic       acc;
  logic [7:0] b;
  logic [4:0] hv;
  logic [7:0] dec;

  assign acc       = uri.valid && uri.ready;
  assign uri.ready = !qstat.full;
  assign b         = uri.in_byte;
  assign hv        = hex_val(b);
  assign dec       = {high_nibble, hv[3:0]};

  // state after this byte, before the last mark is applied
  always_comb begin
    ph_step  = phase;
    mi_step  = match_index;
    esc_step = escape_pending;
    hn_step  = high_nibble;
    hc_step  = high_char;
    err_step = error_code;
    case (phase)
      PH_SCHEME: begin
        if (match_index < 4'(SCHEME_LEN) && b == scheme_char(match_index)) begin
          if (match_index == 4'(SCHEME_LEN - 1)) begin
            ph_step = PH_AFTER;
            mi_step = 4'd0;
          end else begin
            mi_step = match_index + 4'd1;
          end
        end else begin
          ph_step  = PH_REJECT;
          err_step = ST_NOT_FILE;
          esc_step = ESC_NONE;
        end
      end
      PH_AFTER: begin
        if (b == CH_SLASH) begin
          ph_step = PH_PATH;
        end else if (b == host_char(4'd0)) begin
          ph_step = PH_AUTH;
          mi_step = 4'd1;
        end else begin
          ph_step  = PH_REJECT;
          err_step = ST_NOT_FILE;
          esc_step = ESC_NONE;
        end
      end
      PH_AUTH: begin
        if (match_index < 4'(HOST_LEN) && b == host_char(match_index)) begin
          if (match_index == 4'(HOST_LEN - 1)) begin
            ph_step = PH_SLASH;
            mi_step = 4'd0;
          end else begin
            mi_step = match_index + 4'd1;
          end
        end else begin
          ph_step  = PH_REJECT;
          err_step = ST_NOT_FILE;
          esc_step = ESC_NONE;
        end
      end
      PH_SLASH: begin
        if (b == CH_SLASH) begin
          ph_step = PH_PATH;
        end else begin
          ph_step  = PH_REJECT;
          err_step = ST_NOT_FILE;
          esc_step = ESC_NONE;
        end
      end
      PH_PATH: begin
        case (escape_pending)
          ESC_PCT: begin
            if (hv[4]) begin
              hn_step  = hv[3:0];
              hc_step  = b;
              esc_step = ESC_HEX;
            end else begin
              esc_step = (b == CH_PCT) ? ESC_PCT : ESC_NONE;
            end
          end
          ESC_HEX: begin
            if (hv[4]) begin
              esc_step = ESC_NONE;
              if (dec == 8'h00) begin
                ph_step  = PH_REJECT;
                err_step = ST_NUL;
              end
            end else begin
              esc_step = (b == CH_PCT) ? ESC_PCT : ESC_NONE;
            end
          end
          default: begin
            esc_step = (b == CH_PCT) ? ESC_PCT : ESC_NONE;
          end
        endcase
      end
      default: begin
        if (error_code == ST_OK) begin
          err_step = ST_NOT_FILE;
        end
        ph_step = PH_REJECT;
      end
    endcase
  end

  // next state: the last mark returns everything to reset values
  always_comb begin
    phase_next          = phase;
    match_index_next    = match_index;
    escape_pending_next = escape_pending;
    high_nibble_next    = high_nibble;
    high_char_next      = high_char;
    error_code_next     = error_code;
    if (acc) begin
      if (uri.in_last) begin
        phase_next          = PH_SCHEME;
        match_index_next    = 4'd0;
        escape_pending_next = ESC_NONE;
        high_nibble_next    = 4'd0;
        high_char_next      = 8'd0;
        error_code_next     = ST_OK;
      end else begin
        phase_next          = ph_step;
        match_index_next    = mi_step;
        escape_pending_next = esc_step;
        high_nibble_next    = hn_step;
        high_char_next      = hc_step;
        error_code_next     = err_step;
      end
    end
  end

  // results of this byte
  always_comb begin
    result_t [MAX_RES-1:0] it;
    logic [1:0]            n;
    logic [1:0]            st;
    it = '0;
    n  = 2'd0;
    st = ST_OK;
    case (phase)
      PH_AFTER, PH_SLASH: begin
        if (b == CH_SLASH) begin
          it[n] = data_res(b);
          n     = n + 2'd1;
        end
      end
      PH_PATH: begin
        case (escape_pending)
          ESC_PCT: begin
            if (!hv[4]) begin
              it[n] = data_res(CH_PCT);
              n     = n + 2'd1;
              if (b != CH_PCT) begin
                it[n] = data_res(b);
                n     = n + 2'd1;
              end
            end
          end
          ESC_HEX: begin
            if (hv[4]) begin
              if (dec != 8'h00) begin
                it[n] = data_res(dec);
                n     = n + 2'd1;
              end
            end else begin
              it[n] = data_res(CH_PCT);
              n     = n + 2'd1;
              it[n] = data_res(high_char);
              n     = n + 2'd1;
              if (b != CH_PCT) begin
                it[n] = data_res(b);
                n     = n + 2'd1;
              end
            end
          end
          default: begin
            if (b != CH_PCT) begin
              it[n] = data_res(b);
              n     = n + 2'd1;
            end
          end
        endcase
      end
      default: begin
      end
    endcase

    if (uri.in_last) begin
      // flush a cut escape
      if (ph_step == PH_PATH) begin
        if (esc_step == ESC_PCT) begin
          if (n < 2'(MAX_RES)) begin
            it[n] = data_res(CH_PCT);
            n     = n + 2'd1;
          end
        end else if (esc_step == ESC_HEX) begin
          if (n < 2'(MAX_RES)) begin
            it[n] = data_res(CH_PCT);
            n     = n + 2'd1;
          end
          if (n < 2'(MAX_RES)) begin
            it[n] = data_res(hc_step);
            n     = n + 2'd1;
          end
        end
      end
      if (err_step != ST_OK) begin
        st = err_step;
      end else if (ph_step == PH_PATH) begin
        st = ST_OK;
      end else if (ph_step == PH_SCHEME) begin
        st = ST_NOT_FILE;
      end else begin
        st = ST_EMPTY;
      end
      if (st == ST_OK && n != 2'd0) begin
        it[n - 2'd1].out_last = 1'b1;
      end else begin
        if (n == 2'(MAX_RES)) begin
          n = 2'(MAX_RES - 1);
        end
        it[n].out_byte = 8'd0;
        it[n].has_data = 1'b0;
        it[n].out_last = 1'b1;
        it[n].status   = st;
        n              = n + 2'd1;
      end
    end
    entry.items = it;
    entry.count = n;
    push        = acc && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SCHEME;
      match_index    <= 4'd0;
      escape_pending <= ESC_NONE;
      high_nibble    <= 4'd0;
      high_char      <= 8'd0;
      error_code     <= ST_OK;
    end else begin
      phase          <= phase_next;
      match_index    <= match_index_next;
      escape_pending <= escape_pending_next;
      high_nibble    <= high_nibble_next;
      high_char      <= high_char_next;
      error_code     <= error_code_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/fupd_queue.sv */
// short queue of packed result groups between front and back end
// depends on fupd_pkg
`default_nettype none

module fupd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  fupd_pkg::entry_t push_entry,
  input  logic             pop,
  output fupd_pkg::entry_t head,
  output fupd_pkg::qstat_t qstat
);
  import fupd_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [QPTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [QCNT_W-1:0] count, count_next;
  logic              do_push, do_pop;

  assign qstat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = slots[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (do_push) begin
      wr_ptr_next = (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_next = (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_next = count + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_next = count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/fupd_back.sv */
// back end: walks the results of the head group out one request at a time
// depends on fupd_pkg and fupd_out_if
`default_nettype none

module fupd_back (
  input  logic             clk,
  input  logic             rst,
  input  fupd_pkg::entry_t head,
  input  fupd_pkg::qstat_t qstat,
  output logic             pop,
  fupd_out_if.source       path
);
  import fupd_pkg::*;

  logic [1:0] sub, sub_next;
  logic       acc;
  result_t    cur;

  assign cur           = head.items[sub];
  assign path.valid    = !qstat.empty;
  assign path.out_byte = cur.out_byte;
  assign path.has_data = cur.has_data;
  assign path.out_last = cur.out_last;
  assign path.status   = cur.status;
  assign acc           = path.valid && path.ready;

  always_comb begin
    pop      = 1'b0;
    sub_next = sub;
    if (acc) begin
      if (sub == head.count - 2'd1) begin
        pop      = 1'b1;
        sub_next = 2'd0;
      end else begin
        sub_next = sub + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= 2'd0;
    end else begin
      sub <= sub_next;
    end
  end

endmodule

`default_nettype wire

/* test/file_uri_percent_decoder_unit_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench of file_uri_percent_decoder_unit: directed and random uris,
// random idling on both channels and a long output hold-off
// depends on fupd_pkg, fupd_in_if, fupd_out_if and the decoder rtl

module file_uri_percent_decoder_unit_tb;
  import fupd_pkg::*;

  localparam int CLK_PERIOD = 4;
  localparam int HOLD_CYCLES = 150;
  localparam logic [8*SCHEME_LEN-1:0] SCHEME_STR = "file://";
  localparam logic [8*HOST_LEN-1:0] HOST_STR = "localhost";

  typedef struct packed {
    logic [7:0] octet;
    logic       last;
  } uri_req_t;

  logic clk;
  logic rst;

  fupd_in_if  uri_ch ();
  fupd_out_if path_ch ();

  file_uri_percent_decoder_unit uut (
    .clk  (clk),
    .rst  (rst),
    .uri  (uri_ch),
    .path (path_ch)
  );

  uri_req_t uri_pending[$];
  result_t  path_expect[$];
  result_t  step_res[$];
  logic     uri_taken;
  int       send_idle_pct;
  int       recv_stall_pct;
  logic     hold_go;
  logic     rx_hold;
  int       fail_count;

  // decoder state as predicted
  phase_t     pr_phase;
  logic [3:0] pr_idx;
  esc_t       pr_esc;
  logic [3:0] pr_hi_nib;
  logic [7:0] pr_hi_char;
  logic [1:0] pr_err;

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - 8'h30)};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - 8'h61 + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - 8'h41 + 8'd10)};
    return 5'd0;
  endfunction

  function automatic logic [7:0] rand_hex();
    int d;
    d = $urandom_range(15);
    if (d < 10) return 8'(8'h30 + d);
    if ($urandom_range(1) == 0) return 8'(8'h61 + d - 10);
    return 8'(8'h41 + d - 10);
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    result_t r;
    r.out_byte = b;
    r.has_data = 1'b1;
    r.out_last = 1'b0;
    r.status   = ST_OK;
    if (step_res.size() < MAX_RES) step_res.push_back(r);
  endfunction

  function automatic void reset_parser();
    pr_phase   = PH_SCHEME;
    pr_idx     = '0;
    pr_esc     = ESC_NONE;
    pr_hi_nib  = '0;
    pr_hi_char = '0;
    pr_err     = ST_OK;
  endfunction

  function automatic void reject_uri(input logic [1:0] code);
    pr_err   = code;
    pr_phase = PH_REJECT;
    pr_esc   = ESC_NONE;
  endfunction

  function automatic void plain_byte(input logic [7:0] b);
    if (b == CH_PCT) pr_esc = ESC_PCT;
    else add_byte(b);
  endfunction

  // predicts the path requests caused by one uri request
  function automatic void decode_step(input logic [7:0] b, input logic last);
    logic [4:0] h;
    logic [7:0] v;
    logic [1:0] st;
    result_t    fin;
    step_res.delete();
    h = hex_digit(b);
    case (pr_phase)
      PH_SCHEME: begin
        if (pr_idx < SCHEME_LEN && b == SCHEME_STR[8*(SCHEME_LEN-1-pr_idx) +: 8]) begin
          pr_idx = pr_idx + 4'd1;
          if (pr_idx == SCHEME_LEN) begin
            pr_phase = PH_AFTER;
            pr_idx   = '0;
          end
        end else begin
          reject_uri(ST_NOT_FILE);
        end
      end
      PH_AFTER: begin
        if (b == CH_SLASH) begin
          pr_phase = PH_PATH;
          add_byte(b);
        end else if (b == HOST_STR[8*(HOST_LEN-1) +: 8]) begin
          pr_phase = PH_AUTH;
          pr_idx   = 4'd1;
        end else begin
          reject_uri(ST_NOT_FILE);
        end
      end
      PH_AUTH: begin
        if (pr_idx < HOST_LEN && b == HOST_STR[8*(HOST_LEN-1-pr_idx) +: 8]) begin
          pr_idx = pr_idx + 4'd1;
          if (pr_idx == HOST_LEN) begin
            pr_phase = PH_SLASH;
            pr_idx   = '0;
          end
        end else begin
          reject_uri(ST_NOT_FILE);
        end
      end
      PH_SLASH: begin
        if (b == CH_SLASH) begin
          pr_phase = PH_PATH;
          add_byte(b);
        end else begin
          reject_uri(ST_NOT_FILE);
        end
      end
      PH_PATH: begin
        case (pr_esc)
          ESC_PCT: begin
            if (h[4]) begin
              pr_hi_nib  = h[3:0];
              pr_hi_char = b;
              pr_esc     = ESC_HEX;
            end else begin
              add_byte(CH_PCT);
              pr_esc = ESC_NONE;
              plain_byte(b);
            end
          end
          ESC_HEX: begin
            if (h[4]) begin
              v = {pr_hi_nib, h[3:0]};
              pr_esc = ESC_NONE;
              if (v == 8'd0) reject_uri(ST_NUL);
              else add_byte(v);
            end else begin
              add_byte(CH_PCT);
              add_byte(pr_hi_char);
              pr_esc = ESC_NONE;
              plain_byte(b);
            end
          end
          default: begin
            pr_esc = ESC_NONE;
            plain_byte(b);
          end
        endcase
      end
      default: begin
        if (pr_err == ST_OK) pr_err = ST_NOT_FILE;
        pr_phase = PH_REJECT;
      end
    endcase

    if (last) begin
      if (pr_phase == PH_PATH) begin
        if (pr_esc == ESC_PCT) begin
          add_byte(CH_PCT);
        end else if (pr_esc == ESC_HEX) begin
          add_byte(CH_PCT);
          add_byte(pr_hi_char);
        end
        pr_esc = ESC_NONE;
      end
      if (pr_err != ST_OK) st = pr_err;
      else if (pr_phase == PH_PATH) st = ST_OK;
      else if (pr_phase == PH_SCHEME) st = ST_NOT_FILE;
      else st = ST_EMPTY;

      if (st == ST_OK && step_res.size() > 0) begin
        step_res[step_res.size()-1].out_last = 1'b1;
      end else begin
        if (step_res.size() >= MAX_RES) step_res = step_res[0:MAX_RES-2];
        fin.out_byte = 8'd0;
        fin.has_data = 1'b0;
        fin.out_last = 1'b1;
        fin.status   = st;
        step_res.push_back(fin);
      end
      reset_parser();
    end
    foreach (step_res[i]) path_expect.push_back(step_res[i]);
  endfunction

  // request driver and receiver ready
  always @(negedge clk) begin
    if (rst) begin
      uri_ch.valid <= 1'b0;
    end else if (!uri_ch.valid || uri_taken) begin
      if (uri_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        uri_ch.valid   <= 1'b1;
        uri_ch.in_byte <= uri_pending[0].octet;
        uri_ch.in_last <= uri_pending[0].last;
      end else begin
        uri_ch.valid <= 1'b0;
      end
    end
    uri_taken = 1'b0;
    path_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // acceptance, prediction and result checking
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst) begin
      if (uri_ch.valid && uri_ch.ready) begin
        decode_step(uri_ch.in_byte, uri_ch.in_last);
        uri_pending.pop_front();
        uri_taken = 1'b1;
      end
      if (path_ch.valid && path_ch.ready) begin
        got = {path_ch.out_byte, path_ch.has_data, path_ch.out_last, path_ch.status};
        if (path_expect.size() == 0) begin
          $display("%0t: unexpected path request, expected none,", $time,
                   " actual byte=%h data=%b last=%b status=%0d",
                   got.out_byte, got.has_data, got.out_last, got.status);
          fail_count++;
        end else begin
          want = path_expect.pop_front();
          if (got !== want) begin
            $display("%0t: path mismatch,", $time,
                     " expected byte=%h data=%b last=%b status=%0d,",
                     want.out_byte, want.has_data, want.out_last, want.status,
                     " actual byte=%h data=%b last=%b status=%0d",
                     got.out_byte, got.has_data, got.out_last, got.status);
            fail_count++;
          end
        end
      end
    end
  end

  // long output hold-off while the sender keeps offering
  initial begin
    rx_hold = 1'b0;
    wait (hold_go);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    #(2_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic push_raw(input logic [7:0] b, input logic last);
    uri_pending.push_back({b, last});
  endtask

  task automatic push_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) push_raw(s[i], last && (i == s.len() - 1));
  endtask

  task automatic gen_uri();
    logic [7:0] u[$];
    int i;
    int n;
    int kind;
    for (i = 0; i < SCHEME_LEN; i++) u.push_back(SCHEME_STR[8*(SCHEME_LEN-1-i) +: 8]);
    if ($urandom_range(2) == 0)
      for (i = 0; i < HOST_LEN; i++) u.push_back(HOST_STR[8*(HOST_LEN-1-i) +: 8]);
    u.push_back(CH_SLASH);
    n = $urandom_range(8);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1: u.push_back(8'($urandom_range(255)));
        2, 3, 4: begin
          u.push_back(CH_PCT);
          if ($urandom_range(9) == 0) begin
            u.push_back("0");
            u.push_back("0");
          end else begin
            u.push_back(rand_hex());
            u.push_back(rand_hex());
          end
        end
        5: begin
          u.push_back(CH_PCT);
          u.push_back(8'($urandom_range(255)));
        end
        6: begin
          u.push_back(CH_PCT);
          u.push_back(rand_hex());
          u.push_back(8'($urandom_range(255)));
        end
        7: u.push_back(rand_hex());
        8: u.push_back(CH_PCT);
        default: u.push_back(8'($urandom_range(8'h7a, 8'h61)));
      endcase
    end
    kind = $urandom_range(99);
    if (kind < 10) begin
      u[$urandom_range(u.size() - 1)] = 8'($urandom_range(255));
    end else if (kind < 20) begin
      n = $urandom_range(u.size(), 1);
      u = u[0:n-1];
    end
    for (i = 0; i < u.size(); i++) push_raw(u[i], i == u.size() - 1);
  endtask

  task automatic wait_drained();
    while (uri_pending.size() != 0 || path_expect.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall, input int n, input logic hold);
    @(negedge clk);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    while (uri_pending.size() < n) gen_uri();
    if (hold) hold_go = 1'b1;
    wait_drained();
  endtask

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    uri_ch.valid   = 1'b0;
    uri_ch.in_byte = 8'd0;
    uri_ch.in_last = 1'b0;
    path_ch.ready  = 1'b0;
    uri_taken      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_go        = 1'b0;
    fail_count     = 0;
    reset_parser();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // prefix errors and byte extremes
    push_raw(8'h00, 1'b1);
    push_raw(8'hff, 1'b1);
    push_text("fi", 1'b1);
    push_text("File:///", 1'b1);
    push_text("file://", 1'b1);
    push_text("file://x", 1'b1);
    push_text("file://loc", 1'b1);
    push_text("file://localhost", 1'b1);
    push_text("file://localhostx", 1'b1);
    // escapes, upper and lower case
    push_text("file://localhost/a%41%6a", 1'b1);
    push_text("file:///%FF%", 1'b1);
    push_text("file:///%4g", 1'b1);
    push_text("file:///%4%", 1'b1);
    push_text("file:///%%41", 1'b1);
    push_text("file:///%4", 1'b1);
    push_text("file:///%00z", 1'b1);
    // raw nul, cr and lf pass through
    push_text("file:///", 1'b0);
    push_raw(8'h00, 1'b0);
    push_raw(8'h0d, 1'b0);
    push_raw(8'h0a, 1'b0);
    push_raw(8'hff, 1'b1);
    wait_drained();

    run_phase(0, 0, 30, 1'b0);
    run_phase(58, 0, 30, 1'b0);
    run_phase(0, 58, 30, 1'b0);
    run_phase(29, 29, 30, 1'b0);
    run_phase(0, 0, 30, 1'b1);

    repeat (20) @(posedge clk);
    if (path_expect.size() != 0)
      $display("%0t: expected %0d more path requests, actual none", $time,
               path_expect.size());
    if (fail_count == 0 && path_expect.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
